@@ rtl/mwf_pkg.sv @@
// shared types and constants for the magnitude window fifo
`timescale 1ns / 1ps
package mwf_pkg;

    localparam int DEF_BUFFER_DEPTH   = 16;
    localparam int DEF_MAX_WINDOW     = 256;

    localparam int ACCEL_W     = 16;
    localparam int MAG_W       = 17;
    localparam int SQ_W        = 32;
    localparam int ROOT_W      = 16;
    localparam int SUM_W       = 24;
    localparam int CFG_W       = 9;
    localparam int COUNT_OUT_W = 5;

    localparam logic [CFG_W-1:0] SPW_RESET = 9'd50;

    localparam logic OP_SAMPLE = 1'b0;
    localparam logic OP_POP    = 1'b1;

    // register index as decoded from paddr
    localparam logic REG_SPW = 1'b0;

    typedef struct packed {
        logic             is_pop;
        logic [MAG_W-1:0] mag_x;
        logic [MAG_W-1:0] mag_y;
        logic [MAG_W-1:0] mag_z;
    } item_t;

endpackage

@@ rtl/mwf_ram.sv @@
// generic single-write ram with registered read
`timescale 1ns / 1ps
module mwf_ram #(
    parameter int WIDTH = 24,
    parameter int DEPTH = 16
) (
    input  logic                     aclk,
    input  logic                     we,
    input  logic [$clog2(DEPTH)-1:0] waddr,
    input  logic [WIDTH-1:0]         wdata,
    input  logic [$clog2(DEPTH)-1:0] raddr,
    output logic [WIDTH-1:0]         rdata
);

    logic [WIDTH-1:0] mem [DEPTH];
    logic [WIDTH-1:0] rdata_reg;

    always_ff @(posedge aclk) begin
        if (we) begin
            mem[waddr] <= wdata;
        end
        rdata_reg <= mem[raddr];
    end

    assign rdata = rdata_reg;

endmodule

@@ rtl/mwf_front.sv @@
// input side: accepts requests, takes magnitudes, two-entry queue
`timescale 1ns / 1ps
module mwf_front (
    input  logic          aclk,
    input  logic          aresetn,
    input  logic          s_tvalid,
    output logic          s_tready,
    input  logic [47:0]   s_tdata,   // accel_x, accel_y, accel_z
    input  logic [0:0]    s_tuser,   // opcode
    output logic          q_valid,
    output mwf_pkg::item_t q_item,
    input  logic          q_take
);
    import mwf_pkg::*;

    function automatic logic [MAG_W-1:0] abs_mag(input logic [ACCEL_W-1:0] v);
        logic [MAG_W-1:0] ext;
        ext = {1'b0, v};
        if (v[ACCEL_W-1]) begin
            abs_mag = (MAG_W'(1) << ACCEL_W) - ext;
        end else begin
            abs_mag = ext;
        end
    endfunction

    item_t       ent_reg [2];
    logic [1:0]  cnt_reg, cnt_next;
    logic        wr_ptr_reg, wr_ptr_next;
    logic        rd_ptr_reg, rd_ptr_next;
    logic        push, pop;
    item_t       in_item;

    assign s_tready = (cnt_reg != 2'd2);
    assign q_valid  = (cnt_reg != 2'd0);
    assign q_item   = ent_reg[rd_ptr_reg];
    assign push     = s_tvalid & s_tready;
    assign pop      = q_take & q_valid;

    always_comb begin
        in_item.is_pop = (s_tuser[0] == OP_POP);
        in_item.mag_x  = abs_mag(s_tdata[15:0]);
        in_item.mag_y  = abs_mag(s_tdata[31:16]);
        in_item.mag_z  = abs_mag(s_tdata[47:32]);
        wr_ptr_next    = push ? ~wr_ptr_reg : wr_ptr_reg;
        rd_ptr_next    = pop ? ~rd_ptr_reg : rd_ptr_reg;
        cnt_next       = cnt_reg;
        if (push && !pop) begin
            cnt_next = cnt_reg + 2'd1;
        end else if (pop && !push) begin
            cnt_next = cnt_reg - 2'd1;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            cnt_reg    <= 2'd0;
            wr_ptr_reg <= 1'b0;
            rd_ptr_reg <= 1'b0;
        end else begin
            cnt_reg    <= cnt_next;
            wr_ptr_reg <= wr_ptr_next;
            rd_ptr_reg <= rd_ptr_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (push) begin
            ent_reg[wr_ptr_reg] <= in_item;
        end
    end

endmodule

@@ rtl/mwf_root.sv @@
// sum of squares with one shared multiplier, then bitwise integer square root
`timescale 1ns / 1ps
module mwf_root (
    input  logic                        aclk,
    input  logic                        aresetn,
    input  logic                        start,
    input  logic [mwf_pkg::MAG_W-1:0]   mag_x,
    input  logic [mwf_pkg::MAG_W-1:0]   mag_y,
    input  logic [mwf_pkg::MAG_W-1:0]   mag_z,
    output logic                        done,
    output logic [mwf_pkg::ROOT_W-1:0]  root
);
    import mwf_pkg::*;

    localparam logic [1:0] R_IDLE = 2'd0;
    localparam logic [1:0] R_SQ   = 2'd1;
    localparam logic [1:0] R_RT   = 2'd2;

    logic [1:0]         state_reg, state_next;
    logic [3:0]         step_reg, step_next;
    logic               done_reg, done_next;
    logic [MAG_W-1:0]   op_reg [3];
    logic [SQ_W-1:0]    prod_reg, prod_next;
    logic [SQ_W-1:0]    val_reg, val_next;
    logic [SQ_W-1:0]    res_reg, res_next;
    logic [SQ_W-1:0]    probe_reg, probe_next;
    logic [MAG_W-1:0]   op_sel;
    logic [2*MAG_W-1:0] sq_full;
    logic [SQ_W-1:0]    trial;

    assign op_sel  = (step_reg[1:0] == 2'd3) ? op_reg[2] : op_reg[step_reg[1:0]];
    assign sq_full = op_sel * op_sel;
    assign trial   = res_reg + probe_reg;
    assign done    = done_reg;
    assign root    = res_reg[ROOT_W-1:0];

    always_comb begin
        state_next = state_reg;
        step_next  = step_reg;
        done_next  = 1'b0;
        prod_next  = prod_reg;
        val_next   = val_reg;
        res_next   = res_reg;
        probe_next = probe_reg;
        case (state_reg)
            R_IDLE: begin
                if (start) begin
                    state_next = R_SQ;
                    step_next  = 4'd0;
                    val_next   = '0;
                end
            end
            R_SQ: begin
                prod_next = sq_full[SQ_W-1:0];
                if (step_reg != 4'd0) begin
                    val_next = val_reg + prod_reg;
                end
                if (step_reg == 4'd3) begin
                    state_next = R_RT;
                    step_next  = 4'd0;
                    res_next   = '0;
                    probe_next = SQ_W'(1) << (SQ_W - 2);
                end else begin
                    step_next = step_reg + 4'd1;
                end
            end
            R_RT: begin
                if (val_reg >= trial) begin
                    val_next = val_reg - trial;
                    res_next = (res_reg >> 1) + probe_reg;
                end else begin
                    res_next = res_reg >> 1;
                end
                probe_next = probe_reg >> 2;
                step_next  = step_reg + 4'd1;
                if (step_reg == 4'd15) begin
                    state_next = R_IDLE;
                    done_next  = 1'b1;
                end
            end
            default: begin
                state_next = R_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg <= R_IDLE;
            step_reg  <= 4'd0;
            done_reg  <= 1'b0;
        end else begin
            state_reg <= state_next;
            step_reg  <= step_next;
            done_reg  <= done_next;
        end
    end

    always_ff @(posedge aclk) begin
        if (start && state_reg == R_IDLE) begin
            op_reg[0] <= mag_x;
            op_reg[1] <= mag_y;
            op_reg[2] <= mag_z;
        end
        prod_reg  <= prod_next;
        val_reg   <= val_next;
        res_reg   <= res_next;
        probe_reg <= probe_next;
    end

endmodule

@@ rtl/mwf_back.sv @@
// execution side: window accumulation, ring buffer of sums, result register
`timescale 1ns / 1ps
module mwf_back #(
    parameter int BUFFER_DEPTH       = mwf_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_WINDOW_SAMPLES = mwf_pkg::DEF_MAX_WINDOW
) (
    input  logic                       aclk,
    input  logic                       aresetn,
    input  logic                       q_valid,
    input  mwf_pkg::item_t             q_item,
    output logic                       q_take,
    input  logic [mwf_pkg::CFG_W-1:0]  window_len_cfg,
    output logic                       m_tvalid,
    input  logic                       m_tready,
    output logic [31:0]                m_tdata,   // window_sum, stored_count
    output logic [1:0]                 m_tuser    // pop_ok, window_closed
);
    import mwf_pkg::*;

    localparam int AW   = $clog2(BUFFER_DEPTH);
    localparam int CW   = $clog2(BUFFER_DEPTH + 1);
    localparam int TW   = CW + 1;
    localparam int SW   = $clog2(MAX_WINDOW_SAMPLES + 1);
    localparam int CMPW = (SW > CFG_W) ? SW : CFG_W;

    localparam logic [1:0] ST_IDLE = 2'd0;
    localparam logic [1:0] ST_ROOT = 2'd1;
    localparam logic [1:0] ST_ADD  = 2'd2;
    localparam logic [1:0] ST_POP  = 2'd3;

    logic [1:0]             state_reg, state_next;
    logic [AW-1:0]          wpos_reg, wpos_next;
    logic [CW-1:0]          held_reg, held_next;
    logic [SUM_W-1:0]       sum_reg, sum_next;
    logic [SW-1:0]          taken_reg, taken_next;
    logic                   hit_reg, hit_next;
    logic                   m_tvalid_reg, m_tvalid_next;
    logic                   o_pop_ok_reg, o_pop_ok_next;
    logic [SUM_W-1:0]       o_sum_reg, o_sum_next;
    logic                   o_closed_reg, o_closed_next;
    logic [COUNT_OUT_W-1:0] o_count_reg, o_count_next;

    logic                   out_free;
    logic                   root_start, root_done;
    logic [ROOT_W-1:0]      root_val;
    logic                   ram_we;
    logic [SUM_W-1:0]       ram_rdata;
    logic [AW-1:0]          tail;
    logic [TW-1:0]          w_ext, h_ext, t_ext;
    logic [CMPW-1:0]        cfg_ext, len;
    logic [SUM_W:0]         sum_wide;
    logic [SUM_W-1:0]       sum_sat;
    logic [SW-1:0]          taken_inc;
    logic                   closes;

    mwf_root u_root (
        .aclk    (aclk),
        .aresetn (aresetn),
        .start   (root_start),
        .mag_x   (q_item.mag_x),
        .mag_y   (q_item.mag_y),
        .mag_z   (q_item.mag_z),
        .done    (root_done),
        .root    (root_val)
    );

    mwf_ram #(
        .WIDTH (SUM_W),
        .DEPTH (BUFFER_DEPTH)
    ) u_store (
        .aclk  (aclk),
        .we    (ram_we),
        .waddr (wpos_reg),
        .wdata (sum_sat),
        .raddr (tail),
        .rdata (ram_rdata)
    );

    assign out_free = !m_tvalid_reg || m_tready;
    assign m_tvalid = m_tvalid_reg;
    assign m_tdata  = {3'b000, o_count_reg, o_sum_reg};
    assign m_tuser  = {o_closed_reg, o_pop_ok_reg};

    always_comb begin
        w_ext = TW'(wpos_reg);
        h_ext = TW'(held_reg);
        if (w_ext >= h_ext) begin
            t_ext = w_ext - h_ext;
        end else begin
            t_ext = w_ext + TW'(BUFFER_DEPTH) - h_ext;
        end
        tail = t_ext[AW-1:0];

        cfg_ext = CMPW'(window_len_cfg);
        if (cfg_ext == '0) begin
            len = CMPW'(1);
        end else if (cfg_ext > CMPW'(MAX_WINDOW_SAMPLES)) begin
            len = CMPW'(MAX_WINDOW_SAMPLES);
        end else begin
            len = cfg_ext;
        end

        sum_wide  = {1'b0, sum_reg} + (SUM_W + 1)'(root_val);
        sum_sat   = sum_wide[SUM_W] ? {SUM_W{1'b1}} : sum_wide[SUM_W-1:0];
        taken_inc = (taken_reg == SW'(MAX_WINDOW_SAMPLES)) ? taken_reg : taken_reg + SW'(1);
        closes    = (CMPW'(taken_inc) >= len);
    end

    always_comb begin
        state_next    = state_reg;
        wpos_next     = wpos_reg;
        held_next     = held_reg;
        sum_next      = sum_reg;
        taken_next    = taken_reg;
        hit_next      = hit_reg;
        m_tvalid_next = m_tvalid_reg & ~m_tready;
        o_pop_ok_next = o_pop_ok_reg;
        o_sum_next    = o_sum_reg;
        o_closed_next = o_closed_reg;
        o_count_next  = o_count_reg;
        q_take        = 1'b0;
        root_start    = 1'b0;
        ram_we        = 1'b0;
        case (state_reg)
            ST_IDLE: begin
                if (q_valid) begin
                    q_take = 1'b1;
                    if (q_item.is_pop) begin
                        hit_next   = (held_reg != '0);
                        state_next = ST_POP;
                    end else begin
                        root_start = 1'b1;
                        state_next = ST_ROOT;
                    end
                end
            end
            ST_ROOT: begin
                if (root_done) begin
                    state_next = ST_ADD;
                end
            end
            ST_ADD: begin
                if (out_free) begin
                    if (closes) begin
                        ram_we     = 1'b1;
                        wpos_next  = (wpos_reg == AW'(BUFFER_DEPTH - 1)) ? '0
                                                                        : wpos_reg + AW'(1);
                        held_next  = (held_reg == CW'(BUFFER_DEPTH)) ? held_reg
                                                                     : held_reg + CW'(1);
                        sum_next   = '0;
                        taken_next = '0;
                    end else begin
                        sum_next   = sum_sat;
                        taken_next = taken_inc;
                    end
                    m_tvalid_next = 1'b1;
                    o_pop_ok_next = 1'b0;
                    o_sum_next    = '0;
                    o_closed_next = closes;
                    o_count_next  = COUNT_OUT_W'(held_next);
                    state_next    = ST_IDLE;
                end
            end
            ST_POP: begin
                if (out_free) begin
                    if (hit_reg) begin
                        held_next = held_reg - CW'(1);
                    end
                    m_tvalid_next = 1'b1;
                    o_pop_ok_next = hit_reg;
                    o_sum_next    = hit_reg ? ram_rdata : '0;
                    o_closed_next = 1'b0;
                    o_count_next  = COUNT_OUT_W'(held_next);
                    state_next    = ST_IDLE;
                end
            end
            default: begin
                state_next = ST_IDLE;
            end
        endcase
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            state_reg    <= ST_IDLE;
            wpos_reg     <= '0;
            held_reg     <= '0;
            sum_reg      <= '0;
            taken_reg    <= '0;
            m_tvalid_reg <= 1'b0;
        end else begin
            state_reg    <= state_next;
            wpos_reg     <= wpos_next;
            held_reg     <= held_next;
            sum_reg      <= sum_next;
            taken_reg    <= taken_next;
            m_tvalid_reg <= m_tvalid_next;
        end
    end

    always_ff @(posedge aclk) begin
        hit_reg      <= hit_next;
        o_pop_ok_reg <= o_pop_ok_next;
        o_sum_reg    <= o_sum_next;
        o_closed_reg <= o_closed_next;
        o_count_reg  <= o_count_next;
    end

endmodule

@@ rtl/accel_magnitude_window_fifo.sv @@
// top level: request queue, magnitude window engine and configuration port
// order: a sample request passes through the sum of squares and the 16-step square
// root, then updates the window; a pop request reads the ring buffer. Either may stall
// on m_tready, and the engine takes the next request only once the last one is done
// reset: synchronous active-low aresetn clears counters, sum and handshakes
`timescale 1ns / 1ps
module accel_magnitude_window_fifo #(
    parameter int BUFFER_DEPTH       = mwf_pkg::DEF_BUFFER_DEPTH,
    parameter int MAX_WINDOW_SAMPLES = mwf_pkg::DEF_MAX_WINDOW
) (
    input  logic        aclk,
    input  logic        aresetn,
    input  logic        s_tvalid,
    output logic        s_tready,
    input  logic [47:0] s_tdata,   // accel_x, accel_y, accel_z
    input  logic [0:0]  s_tuser,   // opcode
    output logic        m_tvalid,
    input  logic        m_tready,
    output logic [31:0] m_tdata,   // window_sum, stored_count
    output logic [1:0]  m_tuser,   // pop_ok, window_closed
    input  logic        psel,
    input  logic        penable,
    input  logic        pwrite,
    input  logic [2:0]  paddr,
    input  logic [31:0] pwdata,
    output logic [31:0] prdata,
    output logic        pready
);
    import mwf_pkg::*;

    logic [CFG_W-1:0] spw_reg, spw_next;
    logic             q_valid, q_take;
    item_t            q_item;
    logic             cfg_wr;

    assign pready = 1'b1;
    assign cfg_wr = psel & penable & pwrite & pready;

    always_comb begin
        spw_next = spw_reg;
        if (cfg_wr && paddr[2] == REG_SPW) begin
            spw_next = pwdata[CFG_W-1:0];
        end
        if (paddr[2] == REG_SPW) begin
            prdata = {{(32 - CFG_W){1'b0}}, spw_reg};
        end else begin
            prdata = '0;
        end
    end

    always_ff @(posedge aclk) begin
        if (!aresetn) begin
            spw_reg <= SPW_RESET;
        end else begin
            spw_reg <= spw_next;
        end
    end

    mwf_front u_front (
        .aclk     (aclk),
        .aresetn  (aresetn),
        .s_tvalid (s_tvalid),
        .s_tready (s_tready),
        .s_tdata  (s_tdata),
        .s_tuser  (s_tuser),
        .q_valid  (q_valid),
        .q_item   (q_item),
        .q_take   (q_take)
    );

    mwf_back #(
        .BUFFER_DEPTH       (BUFFER_DEPTH),
        .MAX_WINDOW_SAMPLES (MAX_WINDOW_SAMPLES)
    ) u_back (
        .aclk               (aclk),
        .aresetn            (aresetn),
        .q_valid            (q_valid),
        .q_item             (q_item),
        .q_take             (q_take),
        .window_len_cfg     (spw_reg),
        .m_tvalid           (m_tvalid),
        .m_tready           (m_tready),
        .m_tdata            (m_tdata),
        .m_tuser            (m_tuser)
    );

endmodule
